// File: design/plc_pkg.sv
package plc_pkg;

  localparam int NUM_POINTS = 5;
  localparam int MAX_POINTS = 5;
  localparam int LIM_POINTS = (MAX_POINTS < NUM_POINTS) ? MAX_POINTS : NUM_POINTS;

  localparam int CNT_W     = 3;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int SEG_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_POINTS_IN_USE = 3'd5;

  localparam logic [CNT_W-1:0] MIN_ACTIVE = 3'd2;
  localparam logic [CNT_W-1:0] MAX_ACTIVE = CNT_W'(LIM_POINTS);

  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  localparam int MAG_W      = 33;
  localparam int DIV_W      = 16;
  localparam int FIFO_DEPTH = 4;

  typedef logic [NUM_POINTS-1:0][31:0] points_t;

  localparam points_t POINT_RESET = '{
    32'd720243343, 32'd85721407, 32'd59572390, 32'd32768027, 32'd5505033
  };
  localparam logic [CNT_W-1:0] POINTS_IN_USE_RESET = 3'd5;

  typedef struct packed {
    logic [15:0]        a1;
    logic [15:0]        a2;
    logic [15:0]        b1;
    logic [15:0]        b2;
    logic signed [15:0] v;
  } seg_op_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MAG_W-1:0] dq;
    logic [DIV_W-1:0] dmag;
    logic             neg;
    logic             zero;
    logic [15:0]      b1;
  } div_t;

endpackage

// File: design/plc_in_if.sv
interface plc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

// File: design/plc_out_if.sv
interface plc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mapped;

  modport source (output valid, output mapped, input ready);
  modport sink (input valid, input mapped, output ready);
endinterface

// File: design/plc_front.sv
module plc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  plc_in_if.sink                        in_ch,
  input  plc_pkg::points_t              points,
  input  logic [plc_pkg::CNT_W-1:0]     points_in_use,
  input  logic                          fifo_full,
  output logic                          push,
  output plc_pkg::seg_op_t              push_data
);
  import plc_pkg::*;

  logic [15:0]        key [NUM_POINTS];
  logic [15:0]        res [NUM_POINTS];
  logic [NUM_POINTS-1:0] le;
  logic [CNT_W-1:0]   n_act;
  logic [SEG_W-1:0]   seg;
  logic [SEG_W-1:0]   seg_hi;
  logic signed [16:0] v_ext;
  logic               inverse;

  seg_op_t front_r;
  seg_op_t front_nxt;
  logic    front_valid_r;
  logic    front_valid_nxt;

  assign inverse = (in_ch.opcode == OP_INVERSE);
  assign v_ext   = {in_ch.value[15], in_ch.value};

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      key[i] = inverse ? points[i][31:16] : points[i][15:0];
      res[i] = inverse ? points[i][15:0] : points[i][31:16];
      le[i]  = v_ext <= $signed({1'b0, key[i]});
    end
  end

  always_comb begin
    priority if (points_in_use < MIN_ACTIVE) begin
      n_act = MIN_ACTIVE;
    end else if (points_in_use > MAX_ACTIVE) begin
      n_act = MAX_ACTIVE;
    end else begin
      n_act = points_in_use;
    end
  end

  // first segment whose upper point covers the value
  always_comb begin
    seg = SEG_W'(n_act - MIN_ACTIVE);
    for (int i = NUM_POINTS - 2; i >= 0; i--) begin
      if (((i + 1) < int'(n_act)) && le[i+1]) begin
        seg = SEG_W'(i);
      end
    end
    if (le[0]) begin
      seg = '0;
    end
    seg_hi = seg + SEG_W'(1);
  end

  always_comb begin
    front_nxt.a1 = key[seg];
    front_nxt.a2 = key[seg_hi];
    front_nxt.b1 = res[seg];
    front_nxt.b2 = res[seg_hi];
    front_nxt.v  = in_ch.value;
  end

  assign in_ch.ready = !front_valid_r || !fifo_full;
  assign push        = front_valid_r && !fifo_full;
  assign push_data   = front_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      front_r <= front_nxt;
    end
  end

endmodule

// File: design/plc_fifo.sv
module plc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  plc_pkg::seg_op_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output plc_pkg::seg_op_t rd_data,
  output logic             empty
);
  import plc_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  seg_op_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_FW-1:0]  count_r;
  logic [CNT_FW-1:0]  count_nxt;

  assign full    = (count_r == CNT_FW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + CNT_FW'(1);
      2'b01:   count_nxt = count_r - CNT_FW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty)) else $error("read from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + CNT_FW'(1)))
    else $error("queue count did not follow a lone write");

endmodule

// File: design/plc_back.sv
module plc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_avail,
  input  plc_pkg::seg_op_t op,
  output logic             pop,
  plc_out_if.source        out_ch
);
  import plc_pkg::*;

  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  logic advance;

  logic               s1_valid_r;
  logic signed [17:0] s1_dv_r;
  logic signed [16:0] s1_db_r;
  logic signed [16:0] s1_da_r;
  logic [15:0]        s1_b1_r;

  logic               s2_valid_r;
  logic signed [34:0] s2_prod_r;
  logic signed [34:0] s2_prod_nxt;
  logic signed [16:0] s2_da_r;
  logic [15:0]        s2_b1_r;

  div_t             div_r   [MAG_W+1];
  div_t             div_nxt [MAG_W+1];
  logic [MAG_W:0]   div_valid_r;

  logic [16:0]        div_t_w  [MAG_W+1];
  logic [16:0]        div_df_w [MAG_W+1];
  logic               div_ge_w [MAG_W+1];

  logic signed [34:0] prod_abs;
  logic signed [16:0] da_abs;
  logic signed [33:0] q_mag;
  logic signed [33:0] q_sgn;
  logic signed [35:0] sum;

  logic               out_valid_r;
  logic signed [31:0] out_mapped_r;
  logic signed [31:0] out_mapped_nxt;

  assign advance = !out_valid_r || out_ch.ready;
  assign pop     = advance && op_avail;

  assign s2_prod_nxt = s1_dv_r * s1_db_r;

  assign prod_abs = s2_prod_r[34] ? -s2_prod_r : s2_prod_r;
  assign da_abs   = s2_da_r[16] ? -s2_da_r : s2_da_r;

  always_comb begin
    div_nxt[0].rem  = '0;
    div_nxt[0].dq   = prod_abs[MAG_W-1:0];
    div_nxt[0].dmag = da_abs[DIV_W-1:0];
    div_nxt[0].neg  = s2_prod_r[34] ^ s2_da_r[16];
    div_nxt[0].zero = (s2_da_r == '0);
    div_nxt[0].b1   = s2_b1_r;
    div_t_w[0]      = '0;
    div_df_w[0]     = '0;
    div_ge_w[0]     = 1'b0;
    // one quotient bit per stage, restoring
    for (int k = 1; k <= MAG_W; k++) begin
      div_t_w[k]  = {div_r[k-1].rem, div_r[k-1].dq[MAG_W-1]};
      div_ge_w[k] = div_t_w[k] >= {1'b0, div_r[k-1].dmag};
      div_df_w[k] = div_t_w[k] - {1'b0, div_r[k-1].dmag};
      div_nxt[k]      = div_r[k-1];
      div_nxt[k].rem  = div_ge_w[k] ? div_df_w[k][DIV_W-1:0] : div_t_w[k][DIV_W-1:0];
      div_nxt[k].dq   = {div_r[k-1].dq[MAG_W-2:0], div_ge_w[k]};
    end
  end

  always_comb begin
    q_mag = {1'b0, div_r[MAG_W].dq};
    q_sgn = div_r[MAG_W].neg ? -q_mag : q_mag;
    if (div_r[MAG_W].zero) begin
      sum = $signed({20'd0, div_r[MAG_W].b1});
    end else begin
      sum = $signed({20'd0, div_r[MAG_W].b1}) + {{2{q_sgn[33]}}, q_sgn};
    end
    priority if (sum > SAT_HI) begin
      out_mapped_nxt = SAT_HI[31:0];
    end else if (sum < SAT_LO) begin
      out_mapped_nxt = SAT_LO[31:0];
    end else begin
      out_mapped_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      div_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= op_avail;
      s2_valid_r  <= s1_valid_r;
      div_valid_r <= {div_valid_r[MAG_W-1:0], s2_valid_r};
      out_valid_r <= div_valid_r[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dv_r      <= {{2{op.v[15]}}, op.v} - $signed({2'b00, op.a1});
      s1_db_r      <= $signed({1'b0, op.b2}) - $signed({1'b0, op.b1});
      s1_da_r      <= $signed({1'b0, op.a2}) - $signed({1'b0, op.a1});
      s1_b1_r      <= op.b1;
      s2_prod_r    <= s2_prod_nxt;
      s2_da_r      <= s1_da_r;
      s2_b1_r      <= s1_b1_r;
      div_r        <= div_nxt;
      out_mapped_r <= out_mapped_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.mapped = out_mapped_r;

endmodule

// File: design/piecewise_linear_calibration.sv
// piecewise linear calibration mapper
// in_ch carries opcode (forward raw to calibrated, or inverse) and a signed
// 16-bit value; out_ch returns the mapped 32-bit signed result, saturated.
// both channels use valid/ready; an item moves when both are high.
// the cfg port is APB-style: point0..point4 at byte addresses 0x00..0x10,
// points_in_use at 0x14; write only while no item is in flight.
// path: front register, queue, difference and product registers, the 33-step
// pipelined restoring divider behind the multiplier, then the output register.
// throughput: one item per cycle; the search front end and the arithmetic
// back end each take one item a cycle and are joined by a 4-entry queue.
// when out_ch is stalled the back end holds, the queue fills, and then
// in_ch.ready drops; no item is lost or repeated.
// reset (synchronous, rst_n low) empties the pipeline and queue and loads
// the default five-point curve with points_in_use = 5.
module piecewise_linear_calibration (
  input  logic                           clk,
  input  logic                           rst_n,
  plc_in_if.sink                         in_ch,
  plc_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [plc_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import plc_pkg::*;

  points_t              points_r;
  logic [CNT_W-1:0]     points_in_use_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic    fifo_full;
  logic    fifo_empty;
  logic    push;
  logic    pop;
  seg_op_t push_data;
  seg_op_t pop_data;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r        <= POINT_RESET;
      points_in_use_r <= POINTS_IN_USE_RESET;
    end else if (cfg_wr) begin
      if (int'(reg_idx) < NUM_POINTS) begin
        points_r[reg_idx] <= cfg_pwdata;
      end else if (reg_idx == REG_POINTS_IN_USE) begin
        points_in_use_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (int'(reg_idx) < NUM_POINTS) begin
      cfg_prdata = points_r[reg_idx];
    end else if (reg_idx == REG_POINTS_IN_USE) begin
      cfg_prdata = {{(32-CNT_W){1'b0}}, points_in_use_r};
    end
  end

  plc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .points        (points_r),
    .points_in_use (points_in_use_r),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data)
  );

  plc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (fifo_full),
    .rd_en   (pop),
    .rd_data (pop_data),
    .empty   (fifo_empty)
  );

  plc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_avail (!fifo_empty),
    .op       (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: verif/tb_piecewise_linear_calibration.sv
`timescale 1ns / 100ps

module tb_piecewise_linear_calibration;
  import plc_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_POINT0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPARE0 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE1 = 3'd7;
  localparam int NUM_SETTINGS = 7;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] value;
  } raw_item_t;

  logic clk;
  logic rst_n;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  piecewise_linear_calibration u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // curve as the block should hold it
  logic [31:0]      cal_point [NUM_POINTS];
  logic [CNT_W-1:0] cal_count;

  raw_item_t          raw_pending [$];
  logic signed [31:0] mapped_due [$];
  logic signed [31:0] mapped_head;

  logic in_hs;
  int   in_idle_pct;
  int   out_idle_pct;
  int   items_in;
  int   inverse_in;
  int   results_checked;
  int   errors;

  function automatic logic signed [31:0] calib_map(input logic opcode,
                                                   input logic signed [15:0] value);
    longint key [NUM_POINTS];
    longint res [NUM_POINTS];
    longint v;
    longint span;
    longint r;
    int     n;
    int     seg;
    bit     hit;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (opcode == OP_INVERSE) begin
        key[i] = longint'(cal_point[i][31:16]);
        res[i] = longint'(cal_point[i][15:0]);
      end else begin
        key[i] = longint'(cal_point[i][15:0]);
        res[i] = longint'(cal_point[i][31:16]);
      end
    end
    n = int'(cal_count);
    if (n < 2) n = 2;
    if (n > LIM_POINTS) n = LIM_POINTS;
    v = longint'(value);
    seg = n - 2;
    hit = 1'b0;
    if (v <= key[0]) begin
      seg = 0;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (!hit && v <= key[i+1]) begin
          seg = i;
          hit = 1'b1;
        end
      end
    end
    span = key[seg+1] - key[seg];
    if (span == 0) r = res[seg];
    else r = res[seg] + ((v - key[seg]) * (res[seg+1] - res[seg])) / span;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    else if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_hs) begin
      if (raw_pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= raw_pending[0].opcode;
        in_ch.value  <= raw_pending[0].value;
        void'(raw_pending.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    in_hs <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      mapped_due.push_back(calib_map(in_ch.opcode, in_ch.value));
      items_in++;
      if (in_ch.opcode == OP_INVERSE) inverse_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mapped_due.size() == 0) begin
        errors++;
        $display("%0t: mapped expected none got %0d", $time, out_ch.mapped);
      end else begin
        mapped_head = mapped_due.pop_front();
        results_checked++;
        if (out_ch.mapped !== mapped_head) begin
          errors++;
          $display("%0t: mapped expected %0d got %0d", $time, mapped_head, out_ch.mapped);
        end
      end
    end
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (idx < NUM_POINTS) cal_point[idx] = data;
    else if (idx == REG_POINTS_IN_USE) cal_count = data[CNT_W-1:0];
  endtask

  task automatic load_ascending_curve();
    logic [15:0] x;
    logic [15:0] y;
    x = 16'($urandom_range(2000));
    y = 16'($urandom_range(2000));
    for (int i = 0; i < NUM_POINTS; i++) begin
      cfg_write(REG_IDX_W'(REG_POINT0 + i), {y, x});
      x = x + 16'($urandom_range(7000));
      y = y + 16'($urandom_range(7000));
    end
  endtask

  task automatic queue_item(input logic opcode, input logic signed [15:0] value);
    raw_item_t it;
    it.opcode = opcode;
    it.value  = value;
    raw_pending.push_back(it);
  endtask

  task automatic queue_random_items(input int count);
    logic        op;
    logic [15:0] knee;
    int          pick;
    for (int k = 0; k < count; k++) begin
      op   = 1'($urandom_range(1));
      pick = $urandom_range(15);
      if (pick < 5) begin
        // around a breakpoint
        knee = (op == OP_INVERSE)
               ? cal_point[REG_IDX_W'($urandom_range(NUM_POINTS-1))][31:16]
               : cal_point[REG_IDX_W'($urandom_range(NUM_POINTS-1))][15:0];
        queue_item(op, knee + 16'($urandom_range(6)) - 16'd3);
      end else if (pick < 7) begin
        case ($urandom_range(3))
          0: queue_item(op, -16'sd32768);
          1: queue_item(op, 16'sd32767);
          2: queue_item(op, 16'sd0);
          default: queue_item(op, -16'sd1);
        endcase
      end else begin
        queue_item(op, 16'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (raw_pending.size() != 0 || in_ch.valid || mapped_due.size() != 0);
  endtask

  initial begin
    int          fwd_vals [$];
    int          inv_vals [$];
    logic [31:0] twin_pt;
    fwd_vals = '{-32768, 0, 9, 10, 27, 100, 166, 319, 2703, 2704, 32767};
    inv_vals = '{-32768, -1, 84, 85, 500, 909, 1308, 10990, 11000, 32767};
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_FORWARD;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_hs        = 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    items_in        = 0;
    inverse_in      = 0;
    results_checked = 0;
    errors          = 0;
    cal_point = '{POINT_RESET[0], POINT_RESET[1], POINT_RESET[2], POINT_RESET[3],
                  POINT_RESET[4]};
    cal_count = POINTS_IN_USE_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s < 2) begin
        in_idle_pct  = 28;
        out_idle_pct = 52;
      end else if (s < 4) begin
        in_idle_pct  = 52;
        out_idle_pct = 28;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (s)
        0: begin
          foreach (fwd_vals[i]) queue_item(OP_FORWARD, 16'(fwd_vals[i]));
          foreach (inv_vals[i]) queue_item(OP_INVERSE, 16'(inv_vals[i]));
        end
        1: begin
          // a steep falling first segment drives the upper saturation limit
          cfg_write(REG_POINT0, 32'h0000FFFF);
          cfg_write(REG_IDX_W'(REG_POINT0 + 1), 32'hFFFFFFFE);
          cfg_write(REG_IDX_W'(REG_POINT0 + 2), 32'h00000000);
          cfg_write(REG_IDX_W'(REG_POINT0 + 3), 32'hFFFFFFFF);
          cfg_write(REG_IDX_W'(REG_POINT0 + 4), $urandom);
          cfg_write(REG_POINTS_IN_USE, 32'd1);
          cfg_write(REG_SPARE0, $urandom);
          cfg_write(REG_SPARE1, $urandom);
        end
        2: begin
          load_ascending_curve();
          cfg_write(REG_POINTS_IN_USE, 32'd7);
        end
        3: begin
          // zero width in both directions
          twin_pt = $urandom;
          cfg_write(REG_POINT0, twin_pt);
          cfg_write(REG_IDX_W'(REG_POINT0 + 1), twin_pt);
          for (int i = 2; i < NUM_POINTS; i++) begin
            cfg_write(REG_IDX_W'(REG_POINT0 + i), $urandom);
          end
          cfg_write(REG_POINTS_IN_USE, 32'd0);
        end
        4: begin
          load_ascending_curve();
          cfg_write(REG_IDX_W'(REG_POINT0 + 3), cal_point[2]);
          cfg_write(REG_POINTS_IN_USE, 32'd4);
        end
        5: begin
          for (int i = 0; i < NUM_POINTS; i++) begin
            cfg_write(REG_IDX_W'(REG_POINT0 + i), $urandom);
          end
          cfg_write(REG_POINTS_IN_USE, 32'd6);
        end
        default: begin
          load_ascending_curve();
          cfg_write(REG_POINTS_IN_USE, {29'($urandom), 3'd3});
        end
      endcase
      queue_random_items((s == 0) ? 110 : 130);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mapped_due.size() != 0) begin
      errors++;
      $display("%0t: %0d mapped results still outstanding", $time, mapped_due.size());
    end
    $display("mapped %0d items (%0d inverse) over %0d curve settings, %0d results checked",
             items_in, inverse_in, NUM_SETTINGS, results_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: piecewise_linear_calibration.f
design/plc_pkg.sv
design/plc_in_if.sv
design/plc_out_if.sv
design/plc_front.sv
design/plc_fifo.sv
design/plc_back.sv
design/piecewise_linear_calibration.sv
verif/tb_piecewise_linear_calibration.sv
